@@ rtl/plg_pkg.sv @@
`timescale 1ns / 1ps

package plg_pkg;

    localparam int unsigned MAX_WINDOW  = 64;
    localparam int unsigned LFSR_PERIOD = 255;
    localparam int unsigned SEED_MOD    = 254;
    localparam int unsigned WALK_STRIDE = 7;
    localparam int unsigned RETRY_LIMIT = 255;
    localparam int unsigned FC_BYTES    = 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_PICK,
        S_LOAD,
        S_STEP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        start;
        logic [31:0] seed_src;
        logic [31:0] walk_src;
    } t_mod_ctl;

    typedef struct packed {
        logic       busy;
        logic [7:0] seed_rem;
        logic [7:0] walk_rem;
    } t_mod_sts;

    typedef struct packed {
        logic       load;
        logic [7:0] seed;
        logic [7:0] steps;
    } t_lfsr_ctl;

    typedef struct packed {
        logic       busy;
        logic [7:0] value;
    } t_lfsr_sts;

endpackage

@@ rtl/plg_ifs.sv @@
`timescale 1ns / 1ps

interface plg_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_counter;
    logic [6:0]  window_size;
    logic [2:0]  code_rate;
    logic [6:0]  degree;

    modport source (
        output valid, frame_counter, window_size, code_rate, degree,
        input  ready
    );
    modport sink (
        input  valid, frame_counter, window_size, code_rate, degree,
        output ready
    );
endinterface

interface plg_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] parity_line;
    logic        gave_up;

    modport source (
        output valid, parity_line, gave_up,
        input  ready
    );
    modport sink (
        input  valid, parity_line, gave_up,
        output ready
    );
endinterface

@@ rtl/parity_line_generator.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Fields
// i_item   in   frame_counter[31:0], window_size[6:0], code_rate[2:0], degree[6:0]
// o_res    out  parity_line[63:0], gave_up
//
// Accept starts the seed/walk residue pass (one frame-counter byte a cycle);
// each pick loads the LFSR and steps it idx times per draw, idx < 255
// being the walk index; a finished line then moves to the output register.
// The single LFSR stepper, shared by every draw, dominates the worst case.
// Reset is synchronous, active low; i_item is ready only between lines, and a
// finished line waits in the output register while the next word is worked on.
module parity_line_generator (
    input  logic   i_clk,
    input  logic   i_rst_n,
    plg_item_if.sink   i_item,
    plg_res_if.source  o_res
);
    import plg_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_line, n_line;
    logic [7:0]  r_mask, n_mask;
    logic [6:0]  r_deg, n_deg;
    logic [6:0]  r_ones, n_ones;
    logic [7:0]  r_retry, n_retry;
    logic [7:0]  r_idx, n_idx;
    logic [7:0]  r_walk, n_walk;
    logic [7:0]  r_seed, n_seed;
    logic        r_gave, n_gave;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_line, n_out_line;
    logic        r_out_gave, n_out_gave;

    t_mod_ctl    mod_ctl;
    t_mod_sts    mod_sts;
    t_lfsr_ctl   lfsr_ctl;
    t_lfsr_sts   lfsr_sts;

    logic [6:0]  w_clamp;
    logic [7:0]  pos;
    logic [8:0]  idx_sum;
    logic [7:0]  idx_next;

    plg_modred u_modred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mod_ctl),
        .o_sts   (mod_sts)
    );

    plg_lfsr u_lfsr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lfsr_ctl),
        .o_sts   (lfsr_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line      <= '0;
            r_ones      <= '0;
            r_deg       <= '0;
            r_retry     <= '0;
            r_idx       <= '0;
            r_walk      <= '0;
            r_seed      <= 8'd1;
            r_gave      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_ones      <= n_ones;
            r_deg       <= n_deg;
            r_retry     <= n_retry;
            r_idx       <= n_idx;
            r_walk      <= n_walk;
            r_seed      <= n_seed;
            r_gave      <= n_gave;
            r_out_valid <= n_out_valid;
        end
        r_mask     <= n_mask;
        r_out_line <= n_out_line;
        r_out_gave <= n_out_gave;
    end

    assign w_clamp = (i_item.window_size > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW)
                                                            : i_item.window_size;
    assign pos      = lfsr_sts.value & r_mask;
    assign idx_sum  = {1'b0, r_idx} + 9'(WALK_STRIDE);
    assign idx_next = (idx_sum >= 9'(LFSR_PERIOD)) ? 8'(idx_sum - 9'(LFSR_PERIOD))
                                                   : idx_sum[7:0];

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_mask      = r_mask;
        n_deg       = r_deg;
        n_ones      = r_ones;
        n_retry     = r_retry;
        n_idx       = r_idx;
        n_walk      = r_walk;
        n_seed      = r_seed;
        n_gave      = r_gave;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_line  = r_out_line;
        n_out_gave  = r_out_gave;

        mod_ctl.start    = 1'b0;
        mod_ctl.seed_src = i_item.frame_counter + {26'd0, i_item.code_rate, 3'b000};
        mod_ctl.walk_src = i_item.frame_counter;
        lfsr_ctl.load    = 1'b0;
        lfsr_ctl.seed    = r_seed;
        lfsr_ctl.steps   = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_mask        = {1'b0, w_clamp} - 8'd1;
                    n_deg         = (i_item.degree > w_clamp) ? w_clamp : i_item.degree;
                    n_line        = '0;
                    n_ones        = '0;
                    n_retry       = '0;
                    n_gave        = 1'b0;
                    mod_ctl.start = 1'b1;
                    n_state       = S_MOD;
                end
            end
            S_MOD: begin
                if (!mod_sts.busy) begin
                    n_seed  = mod_sts.seed_rem + 8'd1;
                    n_walk  = mod_sts.walk_rem;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_ones < r_deg) begin
                    n_idx   = r_walk;
                    n_retry = '0;
                    n_state = S_LOAD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_LOAD: begin
                lfsr_ctl.load = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                if (!lfsr_sts.busy) begin
                    if (r_line[pos[5:0]]) begin
                        if (r_retry == 8'(RETRY_LIMIT)) begin
                            n_gave  = 1'b1;
                            n_state = S_FINISH;
                        end else begin
                            // taken: walk on by the stride and draw again
                            n_retry = r_retry + 8'd1;
                            n_idx   = idx_next;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_line[pos[5:0]] = 1'b1;
                        n_walk           = pos;
                        n_ones           = r_ones + 7'd1;
                        n_state          = S_PICK;
                    end
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_line  = r_line;
                    n_out_gave  = r_gave;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.parity_line = r_out_line;
    assign o_res.gave_up     = r_out_gave;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_state == S_MOD)
        else $error("accepted word did not start residue pass");

    a_ones_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_line) == 32'(r_ones))
        else $error("line bit count differs from placed count");

    a_deg_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones <= r_deg)
        else $error("more ones placed than degree");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH && (!r_out_valid || o_res.ready)
        |=> r_out_valid && r_state == S_IDLE)
        else $error("finished line not moved to output");
`endif

endmodule

@@ rtl/plg_modred.sv @@
`timescale 1ns / 1ps

module plg_modred (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plg_pkg::t_mod_ctl  i_ctl,
    output plg_pkg::t_mod_sts  o_sts
);
    import plg_pkg::*;

    logic [31:0] r_sa, n_sa;
    logic [31:0] r_sb, n_sb;
    logic [7:0]  r_ra, n_ra;
    logic [7:0]  r_rb, n_rb;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [9:0]  ta;
    logic [8:0]  tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_sa <= n_sa;
        r_sb <= n_sb;
        r_ra <= n_ra;
        r_rb <= n_rb;
    end

    always_comb begin
        n_sa   = r_sa;
        n_sb   = r_sb;
        n_ra   = r_ra;
        n_rb   = r_rb;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        // 256 = 2 mod 254 and 1 mod 255: fold one byte a cycle, MSB first
        ta = {1'b0, r_ra, 1'b0} + {2'b00, r_sa[31:24]};
        if (ta >= 10'(2 * SEED_MOD)) begin
            ta = ta - 10'(2 * SEED_MOD);
        end else if (ta >= 10'(SEED_MOD)) begin
            ta = ta - 10'(SEED_MOD);
        end
        tb = {1'b0, r_rb} + {1'b0, r_sb[31:24]};
        if (tb >= 9'(LFSR_PERIOD)) begin
            tb = tb - 9'(LFSR_PERIOD);
        end
        if (i_ctl.start) begin
            n_sa   = i_ctl.seed_src;
            n_sb   = i_ctl.walk_src;
            n_ra   = '0;
            n_rb   = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_ra  = ta[7:0];
            n_rb  = tb[7:0];
            n_sa  = {r_sa[23:0], 8'h00};
            n_sb  = {r_sb[23:0], 8'h00};
            n_cnt = r_cnt + 2'd1;
            if (r_cnt == 2'(FC_BYTES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_sts.busy     = r_busy;
    assign o_sts.seed_rem = r_ra;
    assign o_sts.walk_rem = r_rb;

endmodule

@@ rtl/plg_lfsr.sv @@
`timescale 1ns / 1ps

module plg_lfsr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plg_pkg::t_lfsr_ctl i_ctl,
    output plg_pkg::t_lfsr_sts o_sts
);
    import plg_pkg::*;

    logic [7:0] r_val, n_val;
    logic [7:0] r_left, n_left;
    logic       fb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= 8'd1;
            r_left <= '0;
        end else begin
            r_val  <= n_val;
            r_left <= n_left;
        end
    end

    always_comb begin
        // x^8+x^6+x^5+x^4+1, shift right, feedback into bit 7
        fb     = r_val[0] ^ r_val[2] ^ r_val[3] ^ r_val[4];
        n_val  = r_val;
        n_left = r_left;
        if (i_ctl.load) begin
            n_val  = i_ctl.seed;
            n_left = i_ctl.steps;
        end else if (r_left != 8'd0) begin
            n_val  = {fb, r_val[7:1]};
            n_left = r_left - 8'd1;
        end
    end

    assign o_sts.busy  = (r_left != 8'd0);
    assign o_sts.value = r_val;

endmodule
